// ----- rtl/tpi_pkg.sv -----
`default_nettype none

package tpi_pkg;

    // input item modes
    typedef enum logic [1:0] {
        MODE_STORE2 = 2'd0,
        MODE_FRAME1 = 2'd1,
        MODE_IDLE   = 2'd2,
        MODE_RX     = 2'd3
    } tpi_mode_t;

    // result kinds
    localparam logic KIND_LINK = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // receiver phase
    typedef enum logic [1:0] {
        RX_HUNT  = 2'd0,
        RX_HELD  = 2'd1,
        RX_TRAIL = 2'd2
    } tpi_rx_phase_t;

    // link constants
    localparam logic [7:0]  IDLE_BYTE  = 8'hFF;
    localparam logic [1:0]  STOP_BITS  = 2'b11;
    localparam logic [3:0]  IDLE_BITS  = 4'hF;
    localparam logic        START_BIT  = 1'b0;

    // command queue
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // one queued command: up to three result bytes, lowest byte first
    typedef struct packed {
        logic        kind;
        logic [1:0]  count;
        logic [23:0] data;
    } tpi_entry_t;

endpackage

`default_nettype wire

// ----- rtl/tpi_fifo.sv -----
`default_nettype none

module tpi_fifo
    import tpi_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  tpi_entry_t      push_data,
    output logic            full,
    input  wire logic       pop,
    output tpi_entry_t      pop_data,
    output logic            empty
);

    tpi_entry_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]       wptr_reg;
    logic [PTR_W-1:0]       wptr_next;
    logic [PTR_W-1:0]       rptr_reg;
    logic [PTR_W-1:0]       rptr_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic                   do_push;
    logic                   do_pop;

    assign full     = (cnt_reg == CNT_W'(FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wptr_next = do_push ? PTR_W'(wptr_reg + 1'b1) : wptr_reg;
        rptr_next = do_pop  ? PTR_W'(rptr_reg + 1'b1) : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tpi_front.sv -----
`default_nettype none

module tpi_front
    import tpi_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] mode,
    input  wire logic [7:0] byte_a,
    input  wire logic [7:0] byte_b,
    input  wire logic       q_full,
    output logic            q_push,
    output tpi_entry_t      q_data
);

    tpi_rx_phase_t  phase_reg;
    tpi_rx_phase_t  phase_next;
    logic [7:0]     first_reg;
    logic [7:0]     first_next;
    logic           accept;
    tpi_mode_t      mode_sel;
    logic [2:0]     zero_pos;
    logic [3:0]     shamt;
    logic [15:0]    rx_word;
    logic [15:0]    rx_shifted;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign mode_sel = tpi_mode_t'(mode);

    // start bit: lowest zero of the held byte, capped at bit 7
    always_comb
    begin
        zero_pos = 3'd7;
        for (int i = 6; i >= 0; i--)
        begin
            if (!first_reg[i])
            begin
                zero_pos = 3'(i);
            end
        end
    end

    assign shamt      = {1'b0, zero_pos} + 4'd1;
    assign rx_word    = {byte_a, first_reg};
    assign rx_shifted = rx_word >> shamt;

    // receiver next state
    always_comb
    begin
        phase_next = phase_reg;
        first_next = first_reg;
        if (accept)
        begin
            if (mode_sel != MODE_RX)
            begin
                phase_next = RX_HUNT;
                first_next = 8'h00;
            end
            else
            begin
                unique case (phase_reg)
                    RX_HELD:
                    begin
                        phase_next = RX_TRAIL;
                    end
                    RX_TRAIL:
                    begin
                        phase_next = RX_HUNT;
                    end
                    default:
                    begin
                        if (byte_a != IDLE_BYTE)
                        begin
                            phase_next = RX_HELD;
                            first_next = byte_a;
                        end
                    end
                endcase
            end
        end
    end

    // classify the item into a queued command
    always_comb
    begin
        q_data.kind  = KIND_LINK;
        q_data.count = 2'd0;
        q_data.data  = '0;
        unique case (mode_sel)
            MODE_STORE2:
            begin
                q_data.count = 2'd3;
                q_data.data  = {STOP_BITS, ^byte_b, byte_b, START_BIT,
                                STOP_BITS, ^byte_a, byte_a, START_BIT};
            end
            MODE_FRAME1:
            begin
                q_data.count = 2'd2;
                q_data.data  = {8'h00, STOP_BITS, ^byte_a, byte_a, START_BIT,
                                IDLE_BITS};
            end
            MODE_IDLE:
            begin
                q_data.count = 2'd2;
                q_data.data  = {8'h00, IDLE_BYTE, IDLE_BYTE};
            end
            MODE_RX:
            begin
                q_data.kind = KIND_DATA;
                if (phase_reg == RX_HELD)
                begin
                    q_data.count = 2'd1;
                end
                q_data.data = {16'h0000, rx_shifted[7:0]};
            end
            default:
            begin
                q_data.count = 2'd0;
            end
        endcase
    end

    // items that cause no result are not queued
    assign q_push = accept && (q_data.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= RX_HUNT;
            first_reg <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            first_reg <= first_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tpi_back.sv -----
`default_nettype none

module tpi_back
    import tpi_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_empty,
    input  tpi_entry_t      q_data,
    output logic            q_pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            kind,
    output logic [7:0]      byte_value,
    output logic            last
);

    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic [23:0]    data_reg;
    logic [23:0]    data_next;
    logic           kind_reg;
    logic           kind_next;
    logic           take;

    // output stage shows the lowest remaining byte
    assign out_valid  = (cnt_reg != 2'd0);
    assign kind       = kind_reg;
    assign byte_value = data_reg[7:0];
    assign last       = (cnt_reg == 2'd1);

    // load a new command when empty or when the final byte leaves
    assign take  = (cnt_reg == 2'd0) || (out_ready && cnt_reg == 2'd1);
    assign q_pop = take && !q_empty;

    always_comb
    begin
        cnt_next  = cnt_reg;
        data_next = data_reg;
        kind_next = kind_reg;
        if (take)
        begin
            if (!q_empty)
            begin
                cnt_next  = q_data.count;
                data_next = q_data.data;
                kind_next = q_data.kind;
            end
            else
            begin
                cnt_next = 2'd0;
            end
        end
        else if (out_ready)
        begin
            cnt_next  = cnt_reg - 2'd1;
            data_next = {8'h00, data_reg[23:8]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        kind_reg <= kind_next;
    end

endmodule

`default_nettype wire

// ----- rtl/tpi_frame_codec.sv -----
// The first result of an item goes through the queue write, then the output stage
// load, before it is valid.
// The back end gives one result byte per cycle while out_ready is high; a two-frame
// store gives 3 result bytes, a single frame or idle pair 2, a received byte at most 1.
// A 2-entry command queue lets input accept continue while results wait.
// Reset (rst_n, async, active low) empties the queue and output stage and puts
// the receiver in start-bit hunt with a cleared held byte.
`default_nettype none

module tpi_frame_codec
    import tpi_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] mode,
    input  wire logic [7:0] byte_a,
    input  wire logic [7:0] byte_b,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            kind,
    output logic [7:0]      byte_value,
    output logic            last
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    tpi_entry_t     q_wdata;
    tpi_entry_t     q_rdata;

    // front: accept, track receiver, build command
    tpi_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .byte_a   (byte_a),
        .byte_b   (byte_b),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    // command queue
    tpi_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    // back: emit bytes one per cycle while out_ready is high
    tpi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .byte_value (byte_value),
        .last       (last)
    );

endmodule

`default_nettype wire
